FILE: hw/rtl/tga_rle_pkg.sv
// Shared types, constants and helper functions for the TGA run-length scanline encoder.
`default_nettype none

package tga_rle_pkg;

	// Largest packet, in pixels.
	localparam int MAX_PACKET_PIXELS = 128;

	// Pixel store geometry: one packet per bank, eight pixels per row.
	localparam int PIXEL_W   = 32;
	localparam int LANES     = 8;
	localparam int LANE_W    = $clog2(LANES);
	localparam int BUF_DEPTH = 128;
	localparam int POS_W     = $clog2(BUF_DEPTH);
	localparam int ROWS      = BUF_DEPTH / LANES;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int COUNT_W   = 4;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Header codes.
	localparam logic [7:0] NO_PACKET  = 8'hFF;
	localparam logic [7:0] RUN_FLAG   = 8'h80;
	localparam logic [7:0] RUN_OF_TWO = 8'h81;
	localparam logic [7:0] MAX_COUNT  = 8'(MAX_PACKET_PIXELS);

	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [LANES-1:0][PIXEL_W-1:0] rle_row_t;

	typedef struct packed {
		pixel_t pixel;
		logic   end_of_line;
	} rle_item_t;

	typedef struct packed {
		logic               has_header;
		logic [7:0]         header;
		logic [COUNT_W-1:0] pixel_count;
		pixel_t             pixel_0;
		pixel_t             pixel_1;
		pixel_t             pixel_2;
		pixel_t             pixel_3;
		pixel_t             pixel_4;
		pixel_t             pixel_5;
		pixel_t             pixel_6;
		pixel_t             pixel_7;
		logic               final_result;
	} rle_result_t;

	// One packet to write out. A run carries its pixel; a raw packet names its bank.
	typedef struct packed {
		logic       valid;
		logic [7:0] header;
		pixel_t     pixel;
		logic       bank;
	} rle_cmd_t;

	// All packets that one input pixel writes out, oldest in cmd_a.
	typedef struct packed {
		rle_cmd_t cmd_a;
		rle_cmd_t cmd_b;
	} rle_entry_t;

	// Pixel store write request from the front.
	typedef struct packed {
		logic             en;
		logic             bank;
		logic [POS_W-1:0] pos;
		pixel_t           pixel;
	} rle_wr_t;

	// The back has read the last row of a bank.
	typedef struct packed {
		logic valid;
		logic bank;
	} rle_release_t;

	// Pixels in a packet with the given header.
	function automatic logic [7:0] pkt_count(input logic [7:0] hdr);
		pkt_count = {1'b0, hdr[6:0]} + 8'd1;
	endfunction

	// True when a packet with this header has reached the size limit.
	function automatic logic at_max(input logic [7:0] hdr);
		at_max = pkt_count(hdr) >= MAX_COUNT;
	endfunction

	function automatic logic is_run(input logic [7:0] hdr);
		is_run = (hdr & RUN_FLAG) != 8'd0;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tga_rle_front.sv
// Front of the encoder: classifies each pixel, tracks the open packet and queues packet writes.
`default_nettype none

module tga_rle_front
	import tga_rle_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire rle_item_t    item,
	output logic              q_push,
	output rle_entry_t        q_entry,
	input  wire logic         q_full,
	output rle_wr_t           wr,
	input  wire rle_release_t rel
);

	logic [7:0] hdr_q;
	pixel_t     prev_q;
	logic       bank_q;
	logic [1:0] busy_q;

	logic       accept;
	logic       same;
	logic [7:0] hdr_n;
	pixel_t     prev_n;
	logic       bank_n;
	rle_wr_t    wr_c;
	rle_cmd_t   cmd_a;
	rle_cmd_t   cmd_b;
	rle_cmd_t   cmd_e;
	rle_cmd_t   slot_a;
	rle_cmd_t   slot_b;
	logic [1:0] busy_n;

	function automatic rle_cmd_t make_cmd(input logic [7:0] hdr, input pixel_t pix,
		input logic bank);
		rle_cmd_t c;
		c.valid  = 1'b1;
		c.header = hdr;
		c.pixel  = pix;
		c.bank   = bank;
		make_cmd = c;
	endfunction

	// A new raw packet always opens in the other bank, so that bank must be drained.
	assign full   = q_full || busy_q[~bank_q];
	assign accept = push && !full;
	assign same   = item.pixel == prev_q;

	// Packet state transition for one pixel.
	always_comb begin
		cmd_a     = '0;
		cmd_b     = '0;
		cmd_e     = '0;
		hdr_n     = hdr_q;
		bank_n    = bank_q;
		prev_n    = item.pixel;
		wr_c      = '0;
		wr_c.pixel = item.pixel;
		wr_c.bank  = bank_q;
		if (hdr_q == NO_PACKET) begin
			hdr_n     = 8'd0;
			bank_n    = ~bank_q;
			wr_c.en   = 1'b1;
			wr_c.bank = ~bank_q;
			wr_c.pos  = '0;
		end else if (is_run(hdr_q)) begin
			if (same) begin
				hdr_n = hdr_q + 8'd1;
				if (at_max(hdr_n)) begin
					cmd_a = make_cmd(hdr_n, item.pixel, bank_q);
					hdr_n = NO_PACKET;
				end
			end else begin
				cmd_a     = make_cmd(hdr_q, prev_q, bank_q);
				hdr_n     = 8'd0;
				bank_n    = ~bank_q;
				wr_c.en   = 1'b1;
				wr_c.bank = ~bank_q;
				wr_c.pos  = '0;
			end
		end else if (hdr_q != 8'd0) begin
			if (same) begin
				// The raw packet gives its last pixel to a new two-pixel run.
				cmd_a = make_cmd(hdr_q - 8'd1, prev_q, bank_q);
				hdr_n = RUN_OF_TWO;
				if (at_max(RUN_OF_TWO)) begin
					cmd_b = make_cmd(RUN_OF_TWO, item.pixel, bank_q);
					hdr_n = NO_PACKET;
				end
			end else if (at_max(hdr_q)) begin
				cmd_a     = make_cmd(hdr_q, prev_q, bank_q);
				hdr_n     = 8'd0;
				bank_n    = ~bank_q;
				wr_c.en   = 1'b1;
				wr_c.bank = ~bank_q;
				wr_c.pos  = '0;
			end else begin
				hdr_n    = hdr_q + 8'd1;
				wr_c.en  = 1'b1;
				wr_c.pos = hdr_n[POS_W-1:0];
			end
		end else begin
			if (same) begin
				hdr_n = RUN_OF_TWO;
				if (at_max(RUN_OF_TWO)) begin
					cmd_a = make_cmd(RUN_OF_TWO, item.pixel, bank_q);
					hdr_n = NO_PACKET;
				end
			end else begin
				hdr_n    = 8'd1;
				wr_c.en  = 1'b1;
				wr_c.pos = POS_W'(1);
			end
		end
		// End of line flushes whatever is still open.
		if (item.end_of_line) begin
			if (hdr_n != NO_PACKET) begin
				cmd_e = make_cmd(hdr_n, item.pixel, bank_n);
			end
			hdr_n  = NO_PACKET;
			prev_n = '0;
		end
	end

	// Pack the packet writes of this pixel, oldest first.
	always_comb begin
		if (cmd_a.valid) begin
			slot_a = cmd_a;
			slot_b = cmd_b.valid ? cmd_b : cmd_e;
		end else if (cmd_b.valid) begin
			slot_a = cmd_b;
			slot_b = cmd_e;
		end else begin
			slot_a = cmd_e;
			slot_b = '0;
		end
	end

	assign q_entry.cmd_a = slot_a;
	assign q_entry.cmd_b = slot_b;
	assign q_push        = accept && slot_a.valid;

	always_comb begin
		wr    = wr_c;
		wr.en = accept && wr_c.en;
	end

	// A bank is busy from the request that writes its packet out until its last row is read.
	always_comb begin
		busy_n = busy_q;
		if (rel.valid) begin
			busy_n[rel.bank] = 1'b0;
		end
		if (accept && slot_a.valid && !is_run(slot_a.header)) begin
			busy_n[slot_a.bank] = 1'b1;
		end
		if (accept && slot_b.valid && !is_run(slot_b.header)) begin
			busy_n[slot_b.bank] = 1'b1;
		end
	end

	// Packet state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= NO_PACKET;
			prev_q <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= busy_n;
			if (accept) begin
				hdr_q  <= hdr_n;
				prev_q <= prev_n;
				bank_q <= bank_n;
			end
		end
	end

	a_write_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !busy_q[wr.bank])
		else $error("pixel written into a bank that is still being read");

	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rel.valid |-> busy_q[rel.bank])
		else $error("release of a bank that was not busy");

endmodule

`default_nettype wire

FILE: hw/rtl/tga_rle_queue.sv
// Short queue of packet write requests between the front and the back.
`default_nettype none

module tga_rle_queue
	import tga_rle_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire rle_entry_t entry,
	output logic            full,
	input  wire logic       pop,
	output rle_entry_t      head,
	output logic            empty
);

	rle_entry_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QPTR_W:0]     count_q;

	assign full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = entries_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("request queue overflow");

endmodule

`default_nettype wire

FILE: hw/rtl/tga_rle_back.sv
// Back of the encoder: holds the two-bank pixel store and turns packet requests into results.
`default_nettype none

module tga_rle_back
	import tga_rle_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire rle_entry_t head,
	input  wire logic       q_empty,
	output logic            q_pop,
	input  wire rle_wr_t    wr,
	output rle_release_t    rel,
	output rle_result_t     result,
	output logic            empty,
	input  wire logic       pop
);

	// Pixel store: bank in the top address bit, eight pixels per row.
	rle_row_t pix_mem [2*ROWS];

	logic [ROW_W-1:0]   row_q;
	logic               slot_q;

	logic               valid_s1;
	rle_row_t           rdata_s1;
	logic               has_hdr_s1;
	logic [7:0]         hdr_s1;
	logic [COUNT_W-1:0] take_s1;
	logic               run_s1;
	pixel_t             run_pix_s1;
	logic               final_s1;

	rle_result_t        ofifo_q [2];
	logic               owp_q;
	logic               orp_q;
	logic [1:0]         ocnt_q;

	rle_cmd_t           cur;
	logic               cur_run;
	logic               last_row;
	logic               last_slot;
	logic [COUNT_W-1:0] take_c;
	logic               pop_fire;
	logic [2:0]         occ;
	logic               room;
	logic               issue;
	pixel_t             lanes_c [LANES];
	rle_result_t        asm_c;

	// Current packet and the row of it to read.
	assign cur       = slot_q ? head.cmd_b : head.cmd_a;
	assign cur_run   = is_run(cur.header);
	assign last_row  = cur_run || (row_q == cur.header[POS_W-1:LANE_W]);
	assign last_slot = slot_q || !head.cmd_b.valid;

	always_comb begin
		if (cur_run) begin
			take_c = COUNT_W'(1);
		end else if (last_row) begin
			take_c = COUNT_W'(cur.header[LANE_W-1:0]) + COUNT_W'(1);
		end else begin
			take_c = COUNT_W'(LANES);
		end
	end

	// Issue a row only if the result buffer will have space when it lands.
	assign pop_fire = pop && !empty;
	assign occ      = {1'b0, ocnt_q} + {2'b0, valid_s1};
	assign room     = occ <= ({2'b0, pop_fire} + 3'd1);
	assign issue    = !q_empty && room;

	assign q_pop     = issue && last_row && last_slot;
	assign rel.valid = issue && !cur_run && last_row;
	assign rel.bank  = cur.bank;

	// Pixel store write and registered row read.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			pix_mem[{wr.bank, wr.pos[POS_W-1:LANE_W]}][wr.pos[LANE_W-1:0]] <= wr.pixel;
		end
		if (issue) begin
			rdata_s1 <= pix_mem[{cur.bank, row_q}];
		end
	end

	// Per-result information that travels with the read.
	always_ff @(posedge clk) begin
		if (issue) begin
			has_hdr_s1 <= row_q == '0;
			hdr_s1     <= (row_q == '0) ? cur.header : 8'd0;
			take_s1    <= take_c;
			run_s1     <= cur_run;
			run_pix_s1 <= cur.pixel;
			final_s1   <= last_row && last_slot;
		end
	end

	// Row and packet sequencing within the queue head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			slot_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				if (!last_row) begin
					row_q <= row_q + ROW_W'(1);
				end else begin
					row_q  <= '0;
					slot_q <= last_slot ? 1'b0 : 1'b1;
				end
			end
		end
	end

	// Build the result from the row that was read.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (run_s1) begin
				lanes_c[i] = (i == 0) ? run_pix_s1 : '0;
			end else begin
				lanes_c[i] = (COUNT_W'(i) < take_s1) ? rdata_s1[i] : '0;
			end
		end
		asm_c.has_header   = has_hdr_s1;
		asm_c.header       = hdr_s1;
		asm_c.pixel_count  = take_s1;
		asm_c.pixel_0      = lanes_c[0];
		asm_c.pixel_1      = lanes_c[1];
		asm_c.pixel_2      = lanes_c[2];
		asm_c.pixel_3      = lanes_c[3];
		asm_c.pixel_4      = lanes_c[4];
		asm_c.pixel_5      = lanes_c[5];
		asm_c.pixel_6      = lanes_c[6];
		asm_c.pixel_7      = lanes_c[7];
		asm_c.final_result = final_s1;
	end

	// Two-entry result buffer.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ofifo_q[owp_q] <= asm_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (valid_s1) begin
				owp_q <= ~owp_q;
			end
			if (pop_fire) begin
				orp_q <= ~orp_q;
			end
			ocnt_q <= ocnt_q + {1'b0, valid_s1} - {1'b0, pop_fire};
		end
	end

	assign empty  = ocnt_q == '0;
	assign result = ofifo_q[orp_q];

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ocnt_q == 2'd2) |-> pop_fire)
		else $error("result buffer overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.pixel_count != '0 && result.pixel_count <= COUNT_W'(LANES)))
		else $error("result pixel count out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/tga_rle_scanline_encoder_core.sv
// Top level of the TGA run-length scanline encoder for 32-bit pixels.
//
// Pixels enter on a queue-style port: an item is taken at a clock edge with push high
// and full low. Each item carries one pixel and an end-of-line flag. Results leave on a
// queue-style port: the oldest result is on result while empty is low and is taken at
// an edge with pop high. A result holds up to eight pixels of one packet; the header
// rides on the first result of the packet and final_result marks the last result that
// a pixel caused.
// Results pass through the request queue, a registered row read and the result buffer.
// Throughput: one pixel per cycle while full is low, and one result per cycle while pop
// is high. A new raw packet opens in the other bank of a two-bank pixel store, so push
// is held off while that bank is still being read out; a packet of n raw pixels is read
// out as ceil(n/8) rows. The four-entry request queue holds off the input when full.
// When the receiver stalls, results wait in a two-entry output buffer and the back stops
// reading; pixels still enter until the queue or the pixel store fills.
// Reset clears all packet state: no open packet, previous pixel zero, both banks free.
`default_nettype none

module tga_rle_scanline_encoder_core
	import tga_rle_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire rle_item_t item,
	output logic           empty,
	input  wire logic      pop,
	output rle_result_t    result
);

	logic         q_push;
	rle_entry_t   q_entry;
	logic         q_full;
	logic         q_pop;
	rle_entry_t   q_head;
	logic         q_empty;
	rle_wr_t      wr;
	rle_release_t rel;

	tga_rle_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_push  (q_push),
		.q_entry (q_entry),
		.q_full  (q_full),
		.wr      (wr),
		.rel     (rel)
	);

	tga_rle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.entry  (q_entry),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head),
		.empty  (q_empty)
	);

	tga_rle_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.wr      (wr),
		.rel     (rel),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

`default_nettype wire

FILE: tb/tb_tga_rle_scanline_encoder_core.sv
// Self-checking testbench for the TGA run-length scanline encoder core.
`default_nettype none

module tb_tga_rle_scanline_encoder_core
	import tga_rle_pkg::*;
();

	localparam int RANDOM_PIXELS    = 24;
	localparam int MAX_STEP_RESULTS = 17;
	localparam int DRAIN_CYCLES     = 20;
	localparam int MAX_PRINTED      = 50;

	typedef pixel_t lane_set_t [LANES];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	rle_item_t   item = '0;
	logic        empty;
	logic        pop = 1'b0;
	rle_result_t result;

	// Encoder state as the predictor sees it.
	logic [7:0]  open_header;
	pixel_t      prior_pixel;
	pixel_t      packet_pixels [BUF_DEPTH];
	rle_result_t step_results [$];
	rle_result_t expected_results [$];

	int mismatches = 0;
	int pixels_sent = 0;
	int push_idle_pct = 0;
	int pop_idle_pct = 0;

	tga_rle_scanline_encoder_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// Free-running clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("tb_tga_rle_scanline_encoder_core NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTED) begin
			$display("ERROR at %0t: %s", $time, what);
		end
		mismatches++;
	endtask

	function automatic void clear_encoder_state();
		open_header = NO_PACKET;
		prior_pixel = '0;
		foreach (packet_pixels[i]) packet_pixels[i] = '0;
		expected_results.delete();
	endfunction

	// A packet is full once its pixel count reaches the limit.
	function automatic bit packet_at_limit(input logic [7:0] hdr);
		return int'(hdr[6:0]) + 1 >= MAX_PACKET_PIXELS;
	endfunction

	// Split one packet into results of up to eight pixels; the header rides on the first.
	function automatic void write_packet(input logic [7:0] hdr);
		int count;
		int pos;
		int take;
		rle_result_t r;
		lane_set_t lanes;
		count = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
		pos = 0;
		while (pos < count && step_results.size() < MAX_STEP_RESULTS) begin
			take = (count - pos > LANES) ? LANES : count - pos;
			foreach (lanes[i]) lanes[i] = (i < take) ? packet_pixels[(pos + i) % BUF_DEPTH] : '0;
			r = '0;
			r.has_header  = (pos == 0);
			r.header      = (pos == 0) ? hdr : 8'd0;
			r.pixel_count = COUNT_W'(take);
			r.pixel_0 = lanes[0];
			r.pixel_1 = lanes[1];
			r.pixel_2 = lanes[2];
			r.pixel_3 = lanes[3];
			r.pixel_4 = lanes[4];
			r.pixel_5 = lanes[5];
			r.pixel_6 = lanes[6];
			r.pixel_7 = lanes[7];
			step_results.push_back(r);
			pos += take;
		end
	endfunction

	// Greedy packet builder: advance the encoder by one pixel and queue what it writes.
	function automatic void predict_pixel(input pixel_t pix, input logic eol);
		logic [7:0] hdr;
		hdr = open_header;
		step_results.delete();
		if (hdr == NO_PACKET) begin
			hdr = 8'd0;
			packet_pixels[0] = pix;
		end else if (hdr[7]) begin
			// An open run grows or is closed by a different pixel.
			if (pix == prior_pixel) begin
				hdr = hdr + 8'd1;
				if (packet_at_limit(hdr)) begin
					write_packet(hdr);
					hdr = NO_PACKET;
				end
			end else begin
				write_packet(hdr);
				hdr = 8'd0;
				packet_pixels[0] = pix;
			end
		end else if (hdr != 8'd0) begin
			// A raw packet of two or more pixels.
			if (pix == prior_pixel) begin
				write_packet(hdr - 8'd1);
				packet_pixels[0] = pix;
				hdr = RUN_OF_TWO;
				if (packet_at_limit(hdr)) begin
					write_packet(hdr);
					hdr = NO_PACKET;
				end
			end else if (int'(hdr) + 1 >= MAX_PACKET_PIXELS) begin
				write_packet(hdr);
				hdr = 8'd0;
				packet_pixels[0] = pix;
			end else begin
				hdr = hdr + 8'd1;
				packet_pixels[hdr[6:0]] = pix;
			end
		end else begin
			// A raw packet of one pixel turns into a run on a repeat.
			if (pix == prior_pixel) begin
				hdr = RUN_OF_TWO;
				if (packet_at_limit(hdr)) begin
					write_packet(hdr);
					hdr = NO_PACKET;
				end
			end else if (MAX_PACKET_PIXELS <= 1) begin
				write_packet(8'd0);
				packet_pixels[0] = pix;
			end else begin
				hdr = 8'd1;
				packet_pixels[1] = pix;
			end
		end
		prior_pixel = pix;
		if (eol) begin
			if (hdr != NO_PACKET) write_packet(hdr);
			hdr = NO_PACKET;
			prior_pixel = '0;
		end
		open_header = hdr;
		if (step_results.size() > 0) step_results[step_results.size() - 1].final_result = 1'b1;
		foreach (step_results[i]) expected_results.push_back(step_results[i]);
	endfunction

	function automatic lane_set_t lanes_of(input rle_result_t r);
		lane_set_t px;
		px = '{r.pixel_0, r.pixel_1, r.pixel_2, r.pixel_3,
		       r.pixel_4, r.pixel_5, r.pixel_6, r.pixel_7};
		return px;
	endfunction

	// Compare one popped result with the oldest expected one.
	task automatic check_result(input rle_result_t got);
		rle_result_t want;
		lane_set_t got_px;
		lane_set_t want_px;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result, header %02h count %0d",
				got.header, got.pixel_count));
			return;
		end
		want = expected_results.pop_front();
		if (got.has_header !== want.has_header)
			report_mismatch($sformatf("has_header %b, expected %b",
				got.has_header, want.has_header));
		if (got.header !== want.header)
			report_mismatch($sformatf("header %02h, expected %02h", got.header, want.header));
		if (got.pixel_count !== want.pixel_count)
			report_mismatch($sformatf("pixel_count %0d, expected %0d",
				got.pixel_count, want.pixel_count));
		got_px = lanes_of(got);
		want_px = lanes_of(want);
		foreach (got_px[i]) begin
			if (got_px[i] !== want_px[i])
				report_mismatch($sformatf("pixel_%0d %08h, expected %08h",
					i, got_px[i], want_px[i]));
		end
		if (got.final_result !== want.final_result)
			report_mismatch($sformatf("final_result %b, expected %b",
				got.final_result, want.final_result));
	endtask

	// Result side: take results with random stalls and check each one.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && pop && empty === 1'b0) check_result(result);
			pop <= ($urandom_range(99) >= pop_idle_pct);
		end
	end

	// Send one pixel request, with random gaps, and predict on acceptance.
	task automatic send_pixel(input pixel_t pix, input logic eol);
		while ($urandom_range(99) < push_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{pixel: pix, end_of_line: eol};
		do @(posedge clk); while (full !== 1'b0);
		predict_pixel(pix, eol);
		pixels_sent++;
	endtask

	task automatic send_line(input pixel_t line [$]);
		foreach (line[i]) send_pixel(line[i], i == line.size() - 1);
	endtask

	// Short lines: single pixel, repeated pixel, raw given up to a run, a raw packet over eight pixels.
	task automatic test_directed_lines();
		push_idle_pct = 0;
		pop_idle_pct = 0;
		send_line('{32'h0000_0000});
		send_line('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_line('{32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0003});
		send_line('{32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
		            32'h0000_0007, 32'h0000_0007});
		send_line('{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
		            32'h0000_0001, 32'hFFFF_FFFE, 32'h1234_5678, 32'hDEAD_BEEF,
		            32'hC0FF_EE00});
	endtask

	// Packets at the size limit: a full run and a full raw packet.
	task automatic test_max_packets();
		pixel_t line [$];
		pixel_t base;
		base = $urandom();
		// A run of the maximum closes at once; the next repeat starts a fresh packet.
		// The input side sends this whole line without a gap.
		push_idle_pct = 0;
		pop_idle_pct = 8;
		repeat (MAX_PACKET_PIXELS + 2) line.push_back(base);
		send_line(line);
		line.delete();
		// A full raw packet, then one more pixel, is the busiest single step.
		// The result side takes results without a gap during this line.
		push_idle_pct = 8;
		pop_idle_pct = 0;
		for (int i = 0; i <= MAX_PACKET_PIXELS; i++) line.push_back(base + pixel_t'(i));
		send_line(line);
	endtask

	// Random scanlines, mostly short, some long and run-heavy.
	task automatic test_random_lines();
		pixel_t palette [4];
		pixel_t pix;
		int first_sent;
		int line_len;
		int repeat_pct;
		int done;
		palette = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), $urandom()};
		first_sent = pixels_sent;
		pix = '0;
		push_idle_pct = 8;
		pop_idle_pct = 8;
		while (pixels_sent - first_sent < RANDOM_PIXELS) begin
			done = pixels_sent - first_sent;
			if ($urandom_range(9) == 0) begin
				line_len = $urandom_range(20, 60);
				repeat_pct = 85;
			end else begin
				line_len = $urandom_range(1, 12);
				repeat_pct = 35;
			end
			// Keep the number of random pixels close to the planned count.
			if (line_len > RANDOM_PIXELS - done) line_len = RANDOM_PIXELS - done;
			for (int i = 0; i < line_len; i++) begin
				if (i == 0 || $urandom_range(99) >= repeat_pct) begin
					case ($urandom_range(3))
						0: pix = palette[$urandom_range(3)];
						1: pix = pix ^ (pixel_t'(1) << $urandom_range(PIXEL_W - 1));
						default: pix = $urandom();
					endcase
				end
				send_pixel(pix, i == line_len - 1);
			end
		end
	endtask

	// Main sequence: reset, tests in turn, drain, verdict.
	initial begin
		clear_encoder_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lines();
		test_max_packets();
		test_random_lines();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_tga_rle_scanline_encoder_core OK");
		end else begin
			$display("tb_tga_rle_scanline_encoder_core NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
